@@ sv/bm3_pkg.sv @@
// ----------------------------------------------------------------------------
// bm3_pkg
// constants, register indexes, mode codes and window operators shared by the
// binary 3x3 morphology block
// ----------------------------------------------------------------------------
package bm3_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_THRESHOLD    = 3'd2;
    localparam logic [2:0] CFG_OP_MODE      = 3'd3;
    localparam logic [2:0] CFG_MASK         = 3'd4;

    // operating modes
    localparam logic [2:0] MODE_BINARIZE = 3'd0;
    localparam logic [2:0] MODE_DILATE   = 3'd1;
    localparam logic [2:0] MODE_ERODE    = 3'd2;
    localparam logic [2:0] MODE_OPEN     = 3'd3;
    localparam logic [2:0] MODE_CLOSE    = 3'd4;
    localparam logic [2:0] MODE_GRAD_DE  = 3'd5;
    localparam logic [2:0] MODE_GRAD_DB  = 3'd6;

    // register reset values
    localparam logic [10:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [10:0] RST_FRAME_HEIGHT = 11'd480;
    localparam logic [7:0]  RST_THRESHOLD    = 8'd127;
    localparam logic [2:0]  RST_OP_MODE      = MODE_DILATE;
    localparam logic [8:0]  RST_MASK         = 9'h1FF;

    // smallest frame side
    localparam int MIN_SIDE = 3;

    // dilation: element k looks at the mirrored window position
    function automatic logic f_dilate(input logic [8:0] win, input logic [8:0] mask);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < 9; k++) begin
            hit = hit | (mask[k] & win[8 - k]);
        end
        return hit;
    endfunction

    // erosion: every set element must see foreground
    function automatic logic f_erode(input logic [8:0] win, input logic [8:0] mask);
        return &(~mask | win);
    endfunction

endpackage

@@ sv/binary_morphology_3x3.sv @@
// ----------------------------------------------------------------------------
// binary_morphology_3x3
// raster pixel stream binarizer followed by two cascaded 3x3 window stages
// (dilate / erode / open / close / gradients) with a column-indexed line
// store per stage
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                     | contents
//  ---------+-----------+-------------------------------+-----------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | blue sample, command
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | pixel, eol, eof
//  cfg      | in        | i_cfg_we                      | register index, data
//
//  one word per clock while no skid word is held; a result is registered in
//  both stages and the output after its window completes. each MAX_WIDTH-deep
//  line store is read at one column, rewritten a stage later, once per item.
//  synchronous active-low reset clears control and configuration; the line
//  stores need no clearing pass since frame edges mask every unwritten row.
//  s_axis_tready drops only while the output skid word is occupied.
// ----------------------------------------------------------------------------
module binary_morphology_3x3 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] blue_sample
    input  logic [0:0]  s_axis_tuser,   // [0] command
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] out_pixel, [7:1] zero
    output logic        m_axis_tlast,   // end_of_line
    output logic [0:0]  m_axis_tuser,   // [0] end_of_frame
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [10:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 3);
    localparam int RS = RW + 2;

    // configuration registers
    logic [10:0] r_cfg_w, r_cfg_h;
    logic [7:0]  r_thr;
    logic [2:0]  r_mode;
    logic [8:0]  r_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= bm3_pkg::RST_FRAME_WIDTH;
            r_cfg_h <= bm3_pkg::RST_FRAME_HEIGHT;
            r_thr   <= bm3_pkg::RST_THRESHOLD;
            r_mode  <= bm3_pkg::RST_OP_MODE;
            r_mask  <= bm3_pkg::RST_MASK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bm3_pkg::CFG_FRAME_WIDTH:  r_cfg_w <= i_cfg_data;
                bm3_pkg::CFG_FRAME_HEIGHT: r_cfg_h <= i_cfg_data;
                bm3_pkg::CFG_THRESHOLD:    r_thr   <= i_cfg_data[7:0];
                bm3_pkg::CFG_OP_MODE:      r_mode  <= i_cfg_data[2:0];
                bm3_pkg::CFG_MASK:         r_mask  <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // clamped frame size
    logic [WW-1:0] w, w_m1, w_m2;
    logic [RS-1:0] h;
    always_comb begin
        int fw, fh;
        fw = int'(r_cfg_w);
        fh = int'(r_cfg_h);
        if (fw < bm3_pkg::MIN_SIDE) fw = bm3_pkg::MIN_SIDE;
        if (fw > MAX_WIDTH) fw = MAX_WIDTH;
        if (fh < bm3_pkg::MIN_SIDE) fh = bm3_pkg::MIN_SIDE;
        if (fh > MAX_HEIGHT) fh = MAX_HEIGHT;
        w    = WW'(fw);
        w_m1 = WW'(fw - 1);
        w_m2 = WW'(fw - 2);
        h    = RS'(fh);
    end

    // pipeline enable and skid state
    logic r_sk_v;
    logic en;
    logic in_acc;
    assign en            = !r_sk_v;
    assign s_axis_tready = en;
    assign in_acc        = s_axis_tvalid && en;

    // input raster position
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    // position decode for the item entering now
    logic          n_bin;
    logic [CW-1:0] n_q1col, n_q2col;
    logic [RS-1:0] n_q1row, n_q2row, rowx;
    logic [3:0]    n_e1, n_e2;          // edges: top, bottom, left, right
    logic          n_q2ok, n_eol, n_eof, wrap_frame, wrap_line;

    always_comb begin
        rowx  = RS'(r_row);
        n_bin = !s_axis_tuser[0] && (rowx < h) && (s_axis_tdata > r_thr);
        // stage one center, w+1 places back
        if (r_col == '0) begin
            n_q1col = CW'(w_m1);
            n_q1row = rowx - RS'(2);
        end else begin
            n_q1col = r_col - CW'(1);
            n_q1row = rowx - RS'(1);
        end
        // stage two center, 2w+2 places back
        if (r_col == '0) begin
            n_q2col = CW'(w_m2);
            n_q2row = rowx - RS'(3);
        end else if (r_col == CW'(1)) begin
            n_q2col = CW'(w_m1);
            n_q2row = rowx - RS'(3);
        end else begin
            n_q2col = r_col - CW'(2);
            n_q2row = rowx - RS'(2);
        end
        n_q2ok = !n_q2row[RS-1] && ($signed(n_q2row) < $signed(h));
        n_e1 = {WW'(n_q1col) == w_m1, n_q1col == '0,
                n_q1row == h - RS'(1), n_q1row == '0};
        n_e2 = {WW'(n_q2col) == w_m1, n_q2col == '0,
                n_q2row == h - RS'(1), n_q2row == '0};
        n_eol = WW'(n_q2col) == w_m1;
        n_eof = n_eol && (n_q2row == h - RS'(1));
        wrap_frame = (rowx > h + RS'(2)) || ((rowx == h + RS'(2)) && (r_col != '0));
        wrap_line  = (WW'(r_col) + WW'(1)) >= w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (wrap_frame) begin
                r_col <= '0;
                r_row <= '0;
            end else if (wrap_line) begin
                r_col <= '0;
                r_row <= r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // stage one line store: [0] one row up, [1] two rows up
    logic [1:0]    mem1 [MAX_WIDTH];
    logic [1:0]    r_rd1;
    logic          r1_v, r1_bin, r1_q2ok, r1_eol, r1_eof;
    logic [CW-1:0] r1_col, r1_q1col;
    logic [3:0]    r1_e1, r1_e2;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd1 <= mem1[r_col];
        end
        if (en) begin
            r1_bin   <= n_bin;
            r1_col   <= r_col;
            r1_q1col <= n_q1col;
            r1_e1    <= n_e1;
            r1_e2    <= n_e2;
            r1_q2ok  <= n_q2ok;
            r1_eol   <= n_eol;
            r1_eof   <= n_eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= in_acc;
        end
    end

    // stage one window: columns left, center, right, bit = row from top
    logic [2:0]    r_w1 [3];
    logic          r2_v, r2_q2ok, r2_eol, r2_eof;
    logic [CW-1:0] r2_q1col;
    logic [3:0]    r2_e1, r2_e2;

    always_ff @(posedge i_clk) begin
        if (en && r1_v) begin
            mem1[r1_col] <= {r_rd1[0], r1_bin};
            r_w1[0]      <= r_w1[1];
            r_w1[1]      <= r_w1[2];
            r_w1[2]      <= {r1_bin, r_rd1[0], r_rd1[1]};
            r2_q1col     <= r1_q1col;
            r2_e1        <= r1_e1;
            r2_e2        <= r1_e2;
            r2_q2ok      <= r1_q2ok;
            r2_eol       <= r1_eol;
            r2_eof       <= r1_eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    // stage one operator on the masked window
    logic [8:0] win1;
    logic [1:0] n_s1;
    always_comb begin
        logic d, e, b;
        for (int k = 0; k < 9; k++) begin
            win1[k] = r_w1[k % 3][k / 3];
        end
        if (r2_e1[0]) win1[2:0] = 3'b000;
        if (r2_e1[1]) win1[8:6] = 3'b000;
        if (r2_e1[2]) begin
            win1[0] = 1'b0;
            win1[3] = 1'b0;
            win1[6] = 1'b0;
        end
        if (r2_e1[3]) begin
            win1[2] = 1'b0;
            win1[5] = 1'b0;
            win1[8] = 1'b0;
        end
        d = bm3_pkg::f_dilate(win1, r_mask);
        e = bm3_pkg::f_erode(win1, r_mask);
        b = win1[4];
        case (r_mode) inside
            bm3_pkg::MODE_ERODE, bm3_pkg::MODE_OPEN:                    n_s1[0] = e;
            bm3_pkg::MODE_DILATE, bm3_pkg::MODE_CLOSE,
            bm3_pkg::MODE_GRAD_DE, bm3_pkg::MODE_GRAD_DB:               n_s1[0] = d;
            default:                                                     n_s1[0] = b;
        endcase
        case (r_mode)
            bm3_pkg::MODE_GRAD_DE: n_s1[1] = e;
            bm3_pkg::MODE_GRAD_DB: n_s1[1] = b;
            default:               n_s1[1] = 1'b0;
        endcase
    end

    // stage two line store: [1:0] one row up, [3:2] two rows up
    logic [3:0]    mem2 [MAX_WIDTH];
    logic [3:0]    r_rd2;
    logic [1:0]    r3_s1;
    logic [CW-1:0] r3_col;
    logic          r3_v, r3_q2ok, r3_eol, r3_eof;
    logic [3:0]    r3_e2;

    always_ff @(posedge i_clk) begin
        if (en && r2_v) begin
            r_rd2    <= mem2[r2_q1col];
            r3_s1    <= n_s1;
            r3_col   <= r2_q1col;
            r3_e2    <= r2_e2;
            r3_q2ok  <= r2_q2ok;
            r3_eol   <= r2_eol;
            r3_eof   <= r2_eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    // stage two window, two bits per position
    logic [5:0] r_w2 [3];
    logic       r4_v, r4_q2ok, r4_eol, r4_eof;
    logic [3:0] r4_e2;

    always_ff @(posedge i_clk) begin
        if (en && r3_v) begin
            mem2[r3_col] <= {r_rd2[1:0], r3_s1};
            r_w2[0]      <= r_w2[1];
            r_w2[1]      <= r_w2[2];
            r_w2[2]      <= {r3_s1, r_rd2[1:0], r_rd2[3:2]};
            r4_e2        <= r3_e2;
            r4_q2ok      <= r3_q2ok;
            r4_eol       <= r3_eol;
            r4_eof       <= r3_eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v;
        end
    end

    // stage two operator
    logic [8:0] win2;
    logic [1:0] ctr2;
    logic       n_res, new_v;
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            win2[k] = r_w2[k % 3][2 * (k / 3)];
        end
        ctr2 = r_w2[1][3:2];
        if (r4_e2[0]) win2[2:0] = 3'b000;
        if (r4_e2[1]) win2[8:6] = 3'b000;
        if (r4_e2[2]) begin
            win2[0] = 1'b0;
            win2[3] = 1'b0;
            win2[6] = 1'b0;
        end
        if (r4_e2[3]) begin
            win2[2] = 1'b0;
            win2[5] = 1'b0;
            win2[8] = 1'b0;
        end
        case (r_mode) inside
            bm3_pkg::MODE_OPEN:                          n_res = bm3_pkg::f_dilate(win2, r_mask);
            bm3_pkg::MODE_CLOSE:                         n_res = bm3_pkg::f_erode(win2, r_mask);
            bm3_pkg::MODE_GRAD_DE, bm3_pkg::MODE_GRAD_DB: n_res = ctr2[0] & ~ctr2[1];
            default:                                     n_res = ctr2[0];
        endcase
        new_v = en && r4_v && r4_q2ok;
    end

    // output register with one skid word
    logic       r_m_v, r_m_pix, r_m_eol, r_m_eof;
    logic       r_sk_pix, r_sk_eol, r_sk_eof;
    logic       out_free;
    assign out_free = !r_m_v || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v  <= 1'b0;
            r_sk_v <= 1'b0;
        end else if (out_free) begin
            if (r_sk_v) begin
                r_m_v  <= 1'b1;
                r_sk_v <= 1'b0;
            end else begin
                r_m_v  <= new_v;
            end
        end else if (new_v) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_sk_v) begin
                r_m_pix <= r_sk_pix;
                r_m_eol <= r_sk_eol;
                r_m_eof <= r_sk_eof;
            end else begin
                r_m_pix <= n_res;
                r_m_eol <= r4_eol;
                r_m_eof <= r4_eof;
            end
        end else if (new_v) begin
            r_sk_pix <= n_res;
            r_sk_eol <= r4_eol;
            r_sk_eof <= r4_eof;
        end
    end

    assign m_axis_tvalid = r_m_v;
    assign m_axis_tdata  = {7'd0, r_m_pix};
    assign m_axis_tlast  = r_m_eol;
    assign m_axis_tuser  = r_m_eof;

endmodule
